// File: src/srd_pkg.sv
// package for the stencil refinement detector: constants, types and weights
package srd_pkg;

   localparam int unsigned DefMaxWidth  = 64;
   localparam int unsigned DefMaxHeight = 64;

   localparam logic [1:0] CsrGridWidth  = 2'd0;
   localparam logic [1:0] CsrGridHeight = 2'd1;
   localparam logic [1:0] CsrGridDepth  = 2'd2;
   localparam logic [1:0] CsrThreshold  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TAP,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [5:0] x;
      logic [5:0] y;
      logic [5:0] z;
      logic       is3d;
   } cell_pos_type;

   // split tap number k (k = c*9 + b*3 + a) into {c, b, a}
   function automatic logic [5:0] tap_digits(input logic [4:0] k);
      logic [4:0] r;
      logic [1:0] a;
      logic [1:0] b;
      logic [1:0] c;
      begin
         if (k >= 5'd18) begin
            c = 2'd2;
            r = k - 5'd18;
         end else if (k >= 5'd9) begin
            c = 2'd1;
            r = k - 5'd9;
         end else begin
            c = 2'd0;
            r = k;
         end
         if (r >= 5'd6) begin
            b = 2'd2;
            r = r - 5'd6;
         end else if (r >= 5'd3) begin
            b = 2'd1;
            r = r - 5'd3;
         end else begin
            b = 2'd0;
         end
         a = r[1:0];
         tap_digits = {c, b, a};
      end
   endfunction

   // weight of tap number k (k = c*9 + b*3 + a) in 2d or 3d mode
   function automatic logic [13:0] tap_weight(input logic is3d, input logic [4:0] k);
      logic [1:0] a;
      logic [1:0] b;
      logic [1:0] c;
      logic [1:0] n;
      logic [13:0] w;
      begin
         {c, b, a} = tap_digits(k);
         n = 2'((a != 2'd1) ? 1 : 0) + 2'((b != 2'd1) ? 1 : 0)
             + 2'((c != 2'd1) ? 1 : 0);
         w = 14'd0;
         if (is3d) begin
            unique case (n)
               2'd0: w = 14'd0;
               2'd1: w = 14'd6554;
               2'd2: w = 14'd1365;
               default: w = 14'd1229;
            endcase
         end else begin
            if (c == 2'd0) begin
               unique case (n)
                  2'd1: w = 14'd0;
                  2'd2: w = 14'd11141;
                  default: w = 14'd5243;
               endcase
            end
         end
         tap_weight = w;
      end
   endfunction

endpackage

// File: src/srd_history.sv
// circular sample history memory with one write and one registered read port
module srd_history #(
   parameter int unsigned Depth = 8323
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [15:0]              wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [15:0]              rd_data
);
   logic [15:0] mem [Depth];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/stencil_refinement_detector.sv
// stencil refinement detector top level
// a judging item reads its 27 (3d) or 9 (2d) taps one after another from one history port
//   (ST_TAP, registered read), finishes the sum (ST_SUM) and compares (ST_OUT); the input
//   is stalled until its result enters the output register, which waits on rsp_stall
// a sample that judges no cell does not stall the input
// reset clears counters and write pointer, loads registers (64, 64, 1, 410); history not cleared
module stencil_refinement_detector #(
   parameter int unsigned MaxWidth  = srd_pkg::DefMaxWidth,
   parameter int unsigned MaxHeight = srd_pkg::DefMaxHeight
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample,
   input  logic               req_start_of_patch,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_cell_x,
   output logic [5:0]         rsp_cell_y,
   output logic [5:0]         rsp_cell_z,
   output logic               rsp_refine,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_data
);
   import srd_pkg::*;

   localparam int unsigned HistLen = 2 * MaxWidth * MaxHeight + 2 * MaxWidth + 3;
   localparam int unsigned AW = $clog2(HistLen);
   localparam int unsigned WW = $clog2(MaxWidth + 1);
   localparam int unsigned HW = $clog2(MaxHeight + 1);
   localparam int unsigned PW = $clog2(MaxWidth * MaxHeight + 1);
   localparam int unsigned CW = (WW > 7) ? WW : 7;
   localparam int unsigned RW = (HW > 7) ? HW : 7;

   logic [6:0]  grid_width_ff, grid_width_in;
   logic [6:0]  grid_height_ff, grid_height_in;
   logic [6:0]  grid_depth_ff, grid_depth_in;
   logic [14:0] thresh_ff, thresh_in;

   state_type   state_ff, state_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [6:0]  pln_ff, pln_in;
   logic [4:0]  k_ff, k_in;
   logic        rvalid_ff, rvalid_in;
   logic [4:0]  rk_ff, rk_in;
   logic signed [35:0] acc_ff, acc_in;
   logic signed [15:0] center_ff, center_in;
   cell_pos_type pos_ff, pos_in;
   logic        out_valid_ff, out_valid_in;
   logic [5:0]  out_x_ff, out_x_in, out_y_ff, out_y_in, out_z_ff, out_z_in;
   logic        out_ref_ff, out_ref_in;
   logic [AW-1:0] base_ff, base_in;

   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [6:0]    d_eff;
   logic [PW-1:0] plane_sz_ff;
   logic          accept, judge, wr_en, mac_done;
   logic [AW-1:0] rd_addr;
   logic [15:0]   rd_data;
   logic [1:0]    ta, tb, tc;
   logic [AW+1:0] back;
   logic [AW+1:0] addr_w;
   logic signed [31:0] prod;
   logic signed [35:0] rounded_full;
   logic signed [19:0] blend;
   logic signed [20:0] diff;
   logic [20:0]   adiff;

   always_comb begin
      if (grid_width_ff == 7'd0) w_eff = WW'(1);
      else if (32'(grid_width_ff) > MaxWidth) w_eff = WW'(MaxWidth);
      else w_eff = WW'(grid_width_ff);
      if (grid_height_ff == 7'd0) h_eff = HW'(1);
      else if (32'(grid_height_ff) > MaxHeight) h_eff = HW'(MaxHeight);
      else h_eff = HW'(grid_height_ff);
      if (grid_depth_ff == 7'd0) d_eff = 7'd1;
      else if (grid_depth_ff > 7'd64) d_eff = 7'd64;
      else d_eff = grid_depth_ff;
   end

   always_ff @(posedge clock) begin
      plane_sz_ff <= PW'(w_eff * h_eff);
   end

   assign csr_ready = 1'b1;
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      grid_depth_in  = grid_depth_ff;
      thresh_in      = thresh_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CsrGridWidth:  grid_width_in  = csr_data[6:0];
            CsrGridHeight: grid_height_in = csr_data[6:0];
            CsrGridDepth:  grid_depth_in  = csr_data[6:0];
            CsrThreshold:  thresh_in      = csr_data;
            default:       thresh_in      = thresh_ff;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign wr_en     = accept;

   logic [CW-1:0] col_cur;
   logic [RW-1:0] row_cur;
   logic [6:0]    pln_cur;
   always_comb begin
      col_cur = req_start_of_patch ? '0 : col_ff;
      row_cur = req_start_of_patch ? '0 : row_ff;
      pln_cur = req_start_of_patch ? '0 : pln_ff;
      judge = (col_cur >= CW'(2)) && (row_cur >= RW'(2)) &&
              ((d_eff == 7'd1) || ((d_eff >= 7'd3) && (pln_cur >= 7'd2)));
   end

   // tap address: back offset for tap k from write pointer of the judged item
   always_comb begin
      {tc, tb, ta} = tap_digits(k_ff);
      back = (AW+2)'(2'd2 - ta) + (AW+2)'(2'd2 - tb) * (AW+2)'(w_eff);
      if (pos_ff.is3d) back = back + (AW+2)'(2'd2 - tc) * (AW+2)'(plane_sz_ff);
      addr_w = {2'b00, base_ff} + (AW+2)'(HistLen) - back;
      if (addr_w >= (AW+2)'(HistLen)) addr_w = addr_w - (AW+2)'(HistLen);
      rd_addr = AW'(addr_w);
   end

   srd_history #(.Depth(HistLen)) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      prod = $signed(rd_data) * $signed({1'b0, tap_weight(pos_ff.is3d, rk_ff)});
      rounded_full = (acc_ff + 36'sd32768) >>> 16;
      blend = 20'(rounded_full);
      diff = 21'(center_ff) - 21'(blend);
      adiff = diff[20] ? 21'(-diff) : diff;
   end

   assign mac_done = rvalid_ff && (rk_ff == (pos_ff.is3d ? 5'd26 : 5'd8));

   always_comb begin
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && judge) state_in = ST_TAP;
         ST_TAP:  if (k_ff == (pos_ff.is3d ? 5'd26 : 5'd8)) state_in = ST_SUM;
         ST_SUM:  if (mac_done) state_in = ST_OUT;
         ST_OUT:  if (!(out_valid_ff && rsp_stall)) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wp_in = wp_ff; col_in = col_ff; row_in = row_ff; pln_in = pln_ff;
      base_in = base_ff; pos_in = pos_ff;
      k_in = k_ff; rvalid_in = 1'b0; rk_in = k_ff;
      acc_in = acc_ff; center_in = center_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_x_in = out_x_ff; out_y_in = out_y_ff; out_z_in = out_z_ff;
      out_ref_in = out_ref_ff;
      if (accept) begin
         wp_in = (wp_ff == AW'(HistLen - 1)) ? '0 : wp_ff + AW'(1);
         base_in = wp_ff;
         pos_in.x = 6'(col_cur - CW'(1));
         pos_in.y = 6'(row_cur - RW'(1));
         pos_in.z = (d_eff == 7'd1) ? 6'd0 : 6'(pln_cur - 7'd1);
         pos_in.is3d = (d_eff != 7'd1);
         k_in = 5'd0;
         acc_in = '0;
         col_in = col_cur + CW'(1);
         row_in = row_cur;
         pln_in = pln_cur;
         if (col_cur + CW'(1) >= CW'(w_eff)) begin
            col_in = '0;
            row_in = row_cur + RW'(1);
            if (row_cur + RW'(1) >= RW'(h_eff)) begin
               row_in = '0;
               pln_in = pln_cur + 7'd1;
               if (pln_cur + 7'd1 >= d_eff) pln_in = '0;
            end
         end
      end
      if (state_ff == ST_TAP) begin
         rvalid_in = 1'b1;
         rk_in = k_ff;
         k_in = k_ff + 5'd1;
      end
      if (rvalid_ff) begin
         acc_in = acc_ff + 36'(prod);
         if (rk_ff == (pos_ff.is3d ? 5'd13 : 5'd4)) center_in = rd_data;
      end
      if (state_ff == ST_OUT && !(out_valid_ff && rsp_stall)) begin
         out_valid_in = 1'b1;
         out_x_in = pos_ff.x;
         out_y_in = pos_ff.y;
         out_z_in = pos_ff.z;
         out_ref_in = (adiff > 21'(thresh_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 7'd64;
         grid_height_ff <= 7'd64;
         grid_depth_ff  <= 7'd1;
         thresh_ff      <= 15'd410;
         state_ff       <= ST_IDLE;
         wp_ff          <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         pln_ff         <= '0;
         rvalid_ff      <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         grid_depth_ff  <= grid_depth_in;
         thresh_ff      <= thresh_in;
         state_ff       <= state_in;
         wp_ff          <= wp_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         pln_ff         <= pln_in;
         rvalid_ff      <= rvalid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      pos_ff    <= pos_in;
      k_ff      <= k_in;
      rk_ff     <= rk_in;
      acc_ff    <= acc_in;
      center_ff <= center_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_z_ff  <= out_z_in;
      out_ref_ff <= out_ref_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_cell_x = out_x_ff;
   assign rsp_cell_y = out_y_ff;
   assign rsp_cell_z = out_z_ff;
   assign rsp_refine = out_ref_ff;
endmodule

// File: sim/stencil_refinement_detector_checker.sv
// checker for the stencil refinement detector: predicts judged cells and compares results
module stencil_refinement_detector_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_sample,
   input  logic               req_start_of_patch,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [5:0]         rsp_cell_x,
   input  logic [5:0]         rsp_cell_y,
   input  logic [5:0]         rsp_cell_z,
   input  logic               rsp_refine,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_data,
   output int                 fail_count,
   output int                 pending
);
   import srd_pkg::*;

   localparam int HistLen = 2 * DefMaxWidth * DefMaxHeight + 2 * DefMaxWidth + 3;

   typedef struct {
      logic [5:0] x;
      logic [5:0] y;
      logic [5:0] z;
      logic       refine;
   } cell_verdict_type;

   cell_verdict_type expected_cells[$];

   logic signed [15:0] history[HistLen];
   int unsigned        write_ptr;
   int unsigned        col, row, plane;
   int unsigned        width_reg, height_reg, depth_reg, thresh_reg;

   function automatic int unsigned eff_size(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint neighbor(int unsigned back);
      return longint'(history[(write_ptr + HistLen - back) % HistLen]);
   endfunction

   // blend weight from the number of axes on which the tap is off center
   function automatic longint blend_weight(bit is3d, int a, int b, int c);
      int n;
      n = (a != 1) + (b != 1) + (c != 1);
      if (is3d) begin
         case (n)
            0: return 0;
            1: return 6554;
            2: return 1365;
            default: return 1229;
         endcase
      end
      case (n)
         0: return 0;
         1: return 11141;
         default: return 5243;
      endcase
   endfunction

   task automatic judge_sample(input logic signed [15:0] s, input logic sop);
      int unsigned     w, h, d;
      longint          sum, centre, diff;
      bit              judged;
      cell_verdict_type v;
      w = eff_size(width_reg, DefMaxWidth);
      h = eff_size(height_reg, DefMaxHeight);
      d = eff_size(depth_reg, 64);
      sum = 0;
      judged = 0;
      centre = 0;
      if (sop) begin
         col = 0;
         row = 0;
         plane = 0;
      end
      history[write_ptr] = s;
      if (d == 1 && col >= 2 && row >= 2) begin
         for (int b = 0; b < 3; b++)
            for (int a = 0; a < 3; a++)
               sum += neighbor((2 - b) * w + (2 - a)) * blend_weight(0, a, b, 1);
         centre = neighbor(w + 1);
         judged = 1;
      end else if (d >= 3 && col >= 2 && row >= 2 && plane >= 2) begin
         for (int c = 0; c < 3; c++)
            for (int b = 0; b < 3; b++)
               for (int a = 0; a < 3; a++)
                  sum += neighbor((2 - c) * w * h + (2 - b) * w + (2 - a))
                         * blend_weight(1, a, b, c);
         centre = neighbor(w * h + w + 1);
         judged = 1;
      end
      if (judged) begin
         diff = centre - ((sum + 32768) >>> 16);
         if (diff < 0) diff = -diff;
         v.x = 6'(col - 1);
         v.y = 6'(row - 1);
         v.z = (d == 1) ? 6'd0 : 6'(plane - 1);
         v.refine = (diff > longint'(thresh_reg));
         expected_cells.insert(expected_cells.size(), v);
      end
      write_ptr = (write_ptr + 1) % HistLen;
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) begin
            row = 0;
            plane++;
            if (plane >= d) plane = 0;
         end
      end
   endtask

   task automatic compare_cell();
      cell_verdict_type e;
      if (expected_cells.size() == 0) begin
         $display("%0t: unexpected item x=%0d y=%0d z=%0d refine=%0d", $time,
                  rsp_cell_x, rsp_cell_y, rsp_cell_z, rsp_refine);
         fail_count++;
         return;
      end
      e = expected_cells.pop_front();
      if (e.x !== rsp_cell_x) begin
         $display("%0t: cell_x expected %0d actual %0d", $time, e.x, rsp_cell_x);
         fail_count++;
      end
      if (e.y !== rsp_cell_y) begin
         $display("%0t: cell_y expected %0d actual %0d", $time, e.y, rsp_cell_y);
         fail_count++;
      end
      if (e.z !== rsp_cell_z) begin
         $display("%0t: cell_z expected %0d actual %0d", $time, e.z, rsp_cell_z);
         fail_count++;
      end
      if (e.refine !== rsp_refine) begin
         $display("%0t: refine expected %0d actual %0d at (%0d,%0d,%0d)", $time,
                  e.refine, rsp_refine, e.x, e.y, e.z);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         expected_cells.delete();
         write_ptr = 0;
         col = 0;
         row = 0;
         plane = 0;
         width_reg = 64;
         height_reg = 64;
         depth_reg = 1;
         thresh_reg = 410;
      end else begin
         if (rsp_valid && !rsp_stall) compare_cell();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrGridWidth: width_reg = csr_data & 15'h7f;
               CsrGridHeight: height_reg = csr_data & 15'h7f;
               CsrGridDepth: depth_reg = csr_data & 15'h7f;
               CsrThreshold: thresh_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) judge_sample(req_sample, req_start_of_patch);
      end
      pending <= expected_cells.size();
   end

   final begin
      if (expected_cells.size() != 0)
         $display("%0t: %0d expected items never arrived", $time, expected_cells.size());
   end

endmodule

// File: sim/stencil_refinement_detector_test.sv
// testbench top for the stencil refinement detector: stimulus, idling and verdict
module stencil_refinement_detector_test;
   import srd_pkg::*;

   localparam int CycleLimit = 4000000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_sample;
   logic               req_start_of_patch;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [5:0]         rsp_cell_x;
   logic [5:0]         rsp_cell_y;
   logic [5:0]         rsp_cell_z;
   logic               rsp_refine;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [14:0]        csr_data;

   int fail_count;
   int pending;
   int cycle_count;
   int burst_left;
   int random_items;
   bit quiet_sender;

   stencil_refinement_detector dut (.*);

   stencil_refinement_detector_checker checker_i (.*);

   initial begin
      clock = 0;
      forever begin
         #1 clock = 1;
         #1 clock = 0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver stall pattern: stretches of no stall, light stall and long stall runs
   int stall_mode;
   int stall_span;
   int stall_run;
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_span <= $urandom_range(20, 300);
      end else begin
         stall_span <= stall_span - 1;
      end
      if (stall_run > 0) begin
         stall_run <= stall_run - 1;
         rsp_stall <= 1;
      end else if (stall_mode == 1) begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end else if (stall_mode == 2 && $urandom_range(0, 15) == 0) begin
         stall_run <= $urandom_range(1, 12);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   function automatic int unsigned eff_size(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic send_sample(input logic signed [15:0] s, input logic sop);
      if (burst_left == 0) begin
         if (!quiet_sender) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1;
      req_sample <= s;
      req_start_of_patch <= sop;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
      burst_left--;
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      burst_left = 0;
      forever begin
         @(negedge clock);
         if (pending == 0) break;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [14:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
   endtask

   task automatic set_grid(input int w, input int h, input int d, input int thr);
      wait_idle();
      csr_write(CsrGridWidth, 15'(w));
      csr_write(CsrGridHeight, 15'(h));
      csr_write(CsrGridDepth, 15'(d));
      csr_write(CsrThreshold, 15'(thr));
      csr_valid <= 0;
      @(posedge clock);
      quiet_sender = ($urandom_range(0, 3) == 0);
   endtask

   // one patch of a smooth field with noise; count samples, restart if asked
   task automatic send_patch(input int count, input bit noisy_starts);
      int base;
      int spread;
      logic signed [15:0] s;
      base = $urandom_range(0, 65535) - 32768;
      spread = 1 << $urandom_range(0, 15);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) s = 16'($urandom);
         else s = 16'(base + $urandom_range(0, spread) - spread / 2);
         send_sample(s, i == 0 || (noisy_starts && $urandom_range(0, 30) == 0));
         random_items++;
      end
   endtask

   task automatic random_phase(input int w, input int h, input int d, input int thr);
      int total;
      set_grid(w, h, d, thr);
      total = eff_size(w, DefMaxWidth) * eff_size(h, DefMaxHeight) * eff_size(d, 64);
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 6))
            0: send_patch($urandom_range(1, total), 0);
            1: send_patch(2 * total + $urandom_range(0, total), 0);
            2: send_patch(total, 1);
            default: send_patch(total, 0);
         endcase
      end
   endtask

   initial begin
      logic signed [15:0] edge_vals[16];
      int thr;
      reset = 1;
      req_valid = 0;
      req_sample = 0;
      req_start_of_patch = 0;
      rsp_stall = 0;
      csr_valid = 0;
      csr_index = CsrGridWidth;
      csr_data = 0;
      cycle_count = 0;
      stall_span = 0;
      stall_mode = 0;
      stall_run = 0;
      burst_left = 0;
      random_items = 0;
      quiet_sender = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: 4x4 plane of extremes, zero threshold, then full threshold
      edge_vals = '{16'sh7fff, -16'sh8000, 16'sh0000, 16'sh7fff,
                    -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh0001,
                    -16'sh0001, 16'sh7fff, 16'sh7fff, -16'sh8000,
                    16'sh5555, -16'sh5556, 16'sh0000, 16'sh7fff};
      set_grid(4, 4, 1, 0);
      foreach (edge_vals[i]) send_sample(edge_vals[i], i == 0);
      set_grid(4, 4, 1, 32767);
      foreach (edge_vals[i]) send_sample(edge_vals[i], i == 0);

      // size extremes, depth two, 3d, and wrap past the last plane
      set_grid(127, 3, 1, 0);
      send_patch(140, 0);
      set_grid(3, 127, 0, 32767);
      send_patch(200, 0);
      set_grid(3, 3, 2, 0);
      send_patch(24, 0);
      set_grid(0, 0, 0, 100);
      send_patch(4, 0);
      set_grid(4, 3, 4, 410);
      send_patch(110, 1);

      random_items = 0;
      while (random_items < 60) begin
         case ($urandom_range(0, 3))
            0: thr = 0;
            1: thr = 32767;
            default: thr = $urandom_range(0, 4000);
         endcase
         random_phase($urandom_range(0, 8), $urandom_range(0, 8),
                      $urandom_range(0, 5), thr);
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
